// ===== design/vdu_pkg.sv =====
// vdu_pkg: shared types, constants and helpers of the vector distance unit
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vdu_pkg;

    localparam int ELEM_WIDTH   = 16;
    localparam int SUM_WIDTH    = 48;
    localparam int COUNT_WIDTH  = 13;
    localparam int METRIC_WIDTH = 3;
    localparam int QUEUE_DEPTH  = 4;

    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam sum_t   SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t   SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam sum_t   ONE_Q16   = sum_t'(65536);

    typedef enum logic [METRIC_WIDTH-1:0] {
        METRIC_DOT     = 3'd0,
        METRIC_NEG_DOT = 3'd1,
        METRIC_SQ_L2   = 3'd2,
        METRIC_L2      = 3'd3,
        METRIC_COSINE  = 3'd4,
        METRIC_L1      = 3'd5,
        METRIC_HAMMING = 3'd6,
        METRIC_NORM_A  = 3'd7
    } metric_t;

    // finished sums of one vector pair, handed from front to back
    typedef struct packed {
        sum_t    dot;
        sum_t    a_sq;
        sum_t    b_sq;
        sum_t    diff_sq;
        sum_t    abs_diff;
        count_t  neq;
        metric_t metric;
    } snap_t;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } queue_status_t;

    function automatic sum_t sat_add(input sum_t s, input logic signed [33:0] t);
        logic signed [SUM_WIDTH:0] w;
        w = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(t);
        if (w[SUM_WIDTH] != w[SUM_WIDTH-1])
            return w[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        return w[SUM_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/vdu_front.sv =====
// vdu_front: takes element pairs, forms products in one stage and
// accumulates the six sums in the next; depends on vdu_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdu_front
    import vdu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  metric_t                      metric,
    input  queue_status_t                qstat,
    output logic                         push,
    output snap_t                        push_data
);

    logic accept;
    logic signed [ELEM_WIDTH:0] diff;
    logic [ELEM_WIDTH-1:0] abs_diff;

    logic s1_valid_reg;
    logic s1_last_reg;
    logic signed [31:0] s1_dot_reg;
    logic [31:0] s1_asq_reg;
    logic [31:0] s1_bsq_reg;
    logic [31:0] s1_dsq_reg;
    logic [ELEM_WIDTH-1:0] s1_absd_reg;
    logic s1_neq_reg;

    sum_t dot_reg, asq_reg, bsq_reg, dsq_reg, absd_reg;
    sum_t dot_next, asq_next, bsq_next, dsq_next, absd_next;
    count_t neq_reg, neq_next;

    // the queue keeps one slot free for the pair still in the product stage
    assign in_stall = qstat.almost_full;
    assign accept   = in_valid & ~qstat.almost_full;

    assign diff     = (ELEM_WIDTH+1)'(elem_a) - (ELEM_WIDTH+1)'(elem_b);
    assign abs_diff = diff[ELEM_WIDTH] ? ELEM_WIDTH'(-diff) : ELEM_WIDTH'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last;
            s1_dot_reg  <= 32'(elem_a) * 32'(elem_b);
            s1_asq_reg  <= 32'(32'(elem_a) * 32'(elem_a));
            s1_bsq_reg  <= 32'(32'(elem_b) * 32'(elem_b));
            s1_dsq_reg  <= 32'(abs_diff) * 32'(abs_diff);
            s1_absd_reg <= abs_diff;
            s1_neq_reg  <= (elem_a != elem_b);
        end
    end

    always_comb
    begin
        dot_next  = sat_add(dot_reg, 34'(s1_dot_reg));
        asq_next  = sat_add(asq_reg, 34'(s1_asq_reg));
        bsq_next  = sat_add(bsq_reg, 34'(s1_bsq_reg));
        dsq_next  = sat_add(dsq_reg, 34'(s1_dsq_reg));
        absd_next = sat_add(absd_reg, {10'b0, s1_absd_reg, 8'b0});
        neq_next  = (s1_neq_reg && neq_reg != COUNT_MAX) ? neq_reg + 1'b1 : neq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            asq_reg  <= '0;
            bsq_reg  <= '0;
            dsq_reg  <= '0;
            absd_reg <= '0;
            neq_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                dot_reg  <= '0;
                asq_reg  <= '0;
                bsq_reg  <= '0;
                dsq_reg  <= '0;
                absd_reg <= '0;
                neq_reg  <= '0;
            end
            else
            begin
                dot_reg  <= dot_next;
                asq_reg  <= asq_next;
                bsq_reg  <= bsq_next;
                dsq_reg  <= dsq_next;
                absd_reg <= absd_next;
                neq_reg  <= neq_next;
            end
        end
    end

    assign push = s1_valid_reg & s1_last_reg;

    always_comb
    begin
        push_data.dot      = dot_next;
        push_data.a_sq     = asq_next;
        push_data.b_sq     = bsq_next;
        push_data.diff_sq  = dsq_next;
        push_data.abs_diff = absd_next;
        push_data.neq      = neq_next;
        push_data.metric   = metric;
    end

endmodule

`default_nettype wire

// ===== design/vdu_queue.sv =====
// vdu_queue: short register queue of finished sums between front and back
// depends on vdu_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdu_queue
    import vdu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  snap_t         push_data,
    input  logic          pop,
    output snap_t         head,
    output queue_status_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    snap_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head              = entry_reg[rd_ptr_reg];
    assign qstat.empty       = (count_reg == '0);
    assign qstat.almost_full = (count_reg >= CW'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(DEPTH)) || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== design/vdu_back.sv =====
// vdu_back: turns finished sums into the selected distance, with an
// iterative square root and divider; depends on vdu_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdu_back
    import vdu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  snap_t         head,
    input  queue_status_t qstat,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output sum_t          distance
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SQRT = 6'b000010,
        B_MUL  = 6'b000100,
        B_CMP  = 6'b001000,
        B_DIV  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t state_reg, state_next;
    metric_t metric_reg, metric_next;
    sum_t    dot_reg, dot_next;
    sum_t    bsq_reg, bsq_next;
    sum_t    res_reg, res_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] root_reg, root_next;
    logic [31:0] ra_reg, ra_next;
    logic [31:0] rb_reg, rb_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [4:0]  step_reg, step_next;
    logic        pass_reg, pass_next;

    logic [63:0] bit_val, trial, sq_x, sq_root;
    logic [64:0] rem2;
    logic [31:0] q_step;
    logic [SUM_WIDTH-1:0] num;
    logic [31:0] q_cap;

    assign num = dot_reg[SUM_WIDTH-1] ? SUM_WIDTH'(-dot_reg) : SUM_WIDTH'(dot_reg);

    // one square root step: settles the next result bit of the root
    always_comb
    begin
        bit_val = 64'(1) << (6'd62 - {step_reg, 1'b0});
        trial   = root_reg + bit_val;
        if (x_reg >= trial)
        begin
            sq_x    = x_reg - trial;
            sq_root = (root_reg >> 1) + bit_val;
        end
        else
        begin
            sq_x    = x_reg;
            sq_root = root_reg >> 1;
        end
    end

    // one quotient bit per step
    always_comb
    begin
        rem2 = {rem_reg, 1'b0};
        if (rem2 >= {1'b0, den_reg})
            q_step = {q_reg[30:0], 1'b1};
        else
            q_step = {q_reg[30:0], 1'b0};
        q_cap = (q_step > 32'(ONE_Q16)) ? 32'(ONE_Q16) : q_step;
    end

    always_comb
    begin
        state_next  = state_reg;
        metric_next = metric_reg;
        dot_next    = dot_reg;
        bsq_next    = bsq_reg;
        res_next    = res_reg;
        x_next      = x_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        pass_next   = pass_reg;
        pop         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop         = 1'b1;
                    metric_next = head.metric;
                    dot_next    = head.dot;
                    bsq_next    = head.b_sq;
                    root_next   = '0;
                    step_next   = '0;
                    pass_next   = 1'b0;
                    state_next  = B_OUT;
                    unique case (head.metric)
                        METRIC_DOT:     res_next = head.dot;
                        METRIC_NEG_DOT: res_next = (head.dot == SUM_MIN) ? SUM_MAX : -head.dot;
                        METRIC_SQ_L2:   res_next = head.diff_sq;
                        METRIC_L2:
                        begin
                            res_next = '0;
                            x_next   = {head.diff_sq, 16'b0};
                            if (head.diff_sq > 0)
                                state_next = B_SQRT;
                        end
                        METRIC_COSINE:
                        begin
                            res_next = ONE_Q16;
                            x_next   = {head.a_sq, 16'b0};
                            if (head.a_sq > 0 && head.b_sq > 0)
                                state_next = B_SQRT;
                        end
                        METRIC_L1:      res_next = head.abs_diff;
                        METRIC_HAMMING: res_next = sum_t'({head.neq, 16'b0});
                        METRIC_NORM_A:
                        begin
                            res_next = '0;
                            x_next   = {head.a_sq, 16'b0};
                            if (head.a_sq > 0)
                                state_next = B_SQRT;
                        end
                    endcase
                end
            end
            B_SQRT:
            begin
                x_next    = sq_x;
                root_next = sq_root;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    if (metric_reg != METRIC_COSINE)
                    begin
                        res_next   = sum_t'(sq_root[31:0]);
                        state_next = B_OUT;
                    end
                    else if (!pass_reg)
                    begin
                        // first root done, start on the norm of b
                        ra_next   = sq_root[31:0];
                        x_next    = {bsq_reg, 16'b0};
                        root_next = '0;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        rb_next    = sq_root[31:0];
                        state_next = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                den_next   = 64'(ra_reg) * 64'(rb_reg);
                state_next = B_CMP;
            end
            B_CMP:
            begin
                rem_next  = 64'(num);
                q_next    = '0;
                step_next = '0;
                if (den_reg == '0)
                begin
                    res_next   = ONE_Q16;
                    state_next = B_OUT;
                end
                else if (64'(num) >= den_reg)
                begin
                    res_next   = dot_reg[SUM_WIDTH-1] ? ONE_Q16 + ONE_Q16 : '0;
                    state_next = B_OUT;
                end
                else
                    state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next  = (rem2 >= {1'b0, den_reg}) ? 64'(rem2 - {1'b0, den_reg})
                                                      : rem2[63:0];
                q_next    = q_step;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    res_next   = dot_reg[SUM_WIDTH-1] ? ONE_Q16 + sum_t'(q_cap)
                                                      : ONE_Q16 - sum_t'(q_cap);
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_stall)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        metric_reg <= metric_next;
        dot_reg    <= dot_next;
        bsq_reg    <= bsq_next;
        res_reg    <= res_next;
        x_reg      <= x_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        step_reg   <= step_next;
        pass_reg   <= pass_next;
    end

    assign out_valid = (state_reg == B_OUT);
    assign distance  = res_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> den_reg != '0)
        else $error("divide with zero denominator");

    a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && metric_reg == METRIC_COSINE)
            |-> (res_reg >= 0 && res_reg <= ONE_Q16 + ONE_Q16))
        else $error("cosine distance out of range");

endmodule

`default_nettype wire

// ===== design/vector_distance_unit.sv =====
// vector_distance_unit: top level with the metric register and APB port
// depends on vdu_pkg, vdu_front, vdu_queue, vdu_back
//
// Usage: element pairs (elem_a, elem_b, last) come in on the input channel,
// one transfer per cycle at most; in_valid with in_stall low moves a pair.
// The pair carrying last closes the vector, and one distance comes out on
// the output channel (out_valid, out_stall) for the metric set in the
// register at address 0. Sums saturate at 48 bits.
// Throughput on the input side is one pair per cycle while in_stall is low.
// A closed vector waits in a four-entry queue; the finisher passes plain
// metrics straight on, takes L2 and norm of a through a square root and
// cosine through two roots, one multiply, a compare and up to 32 divide
// steps. Each pair passes the product stage; the sum stage feeds the queue
// directly. in_stall rises only when the queue nears full, i.e. when short
// vectors outpace the finisher.
// A stalled result holds on distance until taken; the sums keep running.
// Reset clears the sums, the queue, the finisher and the metric (dot).
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_unit
    import vdu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic signed [SUM_WIDTH-1:0]  distance,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    metric_t       metric_reg;
    queue_status_t qstat;
    logic          push, pop;
    snap_t         push_data, head;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            metric_reg <= METRIC_DOT;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            metric_reg <= metric_t'(pwdata[METRIC_WIDTH-1:0]);
    end

    assign prdata = (paddr[2] == 1'b0) ? 32'(metric_reg) : '0;

    vdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .metric    (metric_reg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    vdu_queue #(.DEPTH(DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    vdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance)
    );

endmodule

`default_nettype wire
